### design/cleb_pkg.sv
package cleb_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 128;

  typedef logic [7:0] cleb_char_t;

  localparam cleb_char_t KEY_NUL    = 8'h00;
  localparam cleb_char_t KEY_CTRL_D = 8'h04;
  localparam cleb_char_t KEY_CTRL_H = 8'h08;
  localparam cleb_char_t KEY_LF     = 8'h0a;
  localparam cleb_char_t KEY_CR     = 8'h0d;
  localparam cleb_char_t KEY_CTRL_P = 8'h10;
  localparam cleb_char_t KEY_CTRL_U = 8'h15;
  localparam cleb_char_t KEY_DEL    = 8'h7f;

  localparam logic [7:0] ERASE_MAX = 8'hff;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_KILL_STEP
  } cleb_state_t;

  typedef struct packed {
    logic       kind;
    cleb_char_t key_char;
  } cleb_in_t;

  typedef struct packed {
    logic       echo_valid;
    cleb_char_t echo_char;
    logic [7:0] erase_count;
    logic       line_ready;
    logic       dump_request;
    logic       read_valid;
    cleb_char_t read_char;
  } cleb_out_t;

endpackage

### design/cleb_ram.sv
module cleb_ram
  import cleb_pkg::*;
#(
  parameter int DEPTH = DEFAULT_BUFFER_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  cleb_char_t    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output cleb_char_t    rd_data
);

  cleb_char_t mem [DEPTH];
  cleb_char_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/console_line_edit_buffer.sv
// Results: most keys answer on out_valid in the cycle after accept; a read answers from
//   ST_READ_WAIT, and a Ctrl-U kill erasing k characters (k below BUFFER_DEPTH) answers
//   when its ST_KILL_STEP walk ends. Throughput: one key beat per cycle while busy is low;
//   busy holds in ST_READ_WAIT and in the kill walk (one character per cycle, one read port).
// Reset: synchronous, active low; clears all three indices and the sequencer. The line
//   store is not cleared. The receiver cannot stall: each result shows for one cycle.
module console_line_edit_buffer
  import cleb_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  cleb_in_t  in_item,
  output logic      out_valid,
  output cleb_out_t out_item
);

  // Slot address and running index widths; indices count modulo 2*depth so that
  // a full ring and an empty ring read differently.
  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int IW = AW + 1;
  localparam logic [IW-1:0] DEPTH_I   = IW'(BUFFER_DEPTH);
  localparam logic [IW-1:0] DEPTH_M1  = IW'(BUFFER_DEPTH - 1);
  localparam logic [IW-1:0] SPAN_LAST = IW'(2 * BUFFER_DEPTH - 1);
  localparam logic [IW-1:0] SPAN_MOD  = IW'(2 * BUFFER_DEPTH);

  function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] x);
    return (x == SPAN_LAST) ? '0 : x + IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] x);
    return (x == '0) ? SPAN_LAST : x - IW'(1);
  endfunction

  // Modular distance; when a < b the IW-bit wrap lands on the right value.
  function automatic logic [IW-1:0] idx_dist(input logic [IW-1:0] a, input logic [IW-1:0] b);
    return (a >= b) ? a - b : a - b + SPAN_MOD;
  endfunction

  function automatic logic [AW-1:0] slot_of(input logic [IW-1:0] x);
    return (x >= DEPTH_I) ? AW'(x - DEPTH_I) : AW'(x);
  endfunction

  // Sequencer and index registers
  cleb_state_t   state_r, state_nxt;
  logic [IW-1:0] read_idx_r, read_idx_nxt;
  logic [IW-1:0] commit_idx_r, commit_idx_nxt;
  logic [IW-1:0] edit_idx_r, edit_idx_nxt;
  logic [7:0]    erase_cnt_r, erase_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  cleb_out_t     out_item_r, out_item_nxt;

  // Line store ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  cleb_char_t    wr_data;
  logic          rd_en;
  logic [IW-1:0] rd_idx;
  cleb_char_t    rd_data;

  // Shared index arithmetic
  logic [IW-1:0] edit_prev;
  logic [IW-1:0] edit_prev2;
  logic [IW-1:0] fill_level;
  logic [7:0]    erase_cnt_inc;
  cleb_char_t    store_char;

  assign edit_prev     = idx_prev(edit_idx_r);
  assign edit_prev2    = idx_prev(edit_prev);
  assign fill_level    = idx_dist(edit_idx_r, read_idx_r);
  assign erase_cnt_inc = (erase_cnt_r == ERASE_MAX) ? erase_cnt_r : erase_cnt_r + 8'd1;
  assign store_char    = (in_item.key_char == KEY_CR) ? KEY_LF : in_item.key_char;

  cleb_ram #(
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(slot_of(rd_idx)),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      read_idx_r   <= '0;
      commit_idx_r <= '0;
      edit_idx_r   <= '0;
      erase_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      read_idx_r   <= read_idx_nxt;
      commit_idx_r <= commit_idx_nxt;
      edit_idx_r   <= edit_idx_nxt;
      erase_cnt_r  <= erase_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload; qualified by out_valid_r only.
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    read_idx_nxt   = read_idx_r;
    commit_idx_nxt = commit_idx_r;
    edit_idx_nxt   = edit_idx_r;
    erase_cnt_nxt  = erase_cnt_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = '0;
    wr_en          = 1'b0;
    wr_addr        = slot_of(edit_idx_r);
    wr_data        = store_char;
    rd_en          = 1'b0;
    rd_idx         = edit_prev;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_item.kind) begin
            // Consumer read: fetch the oldest committed character if any.
            if (read_idx_r != commit_idx_r) begin
              rd_en     = 1'b1;
              rd_idx    = read_idx_r;
              state_nxt = ST_READ_WAIT;
            end else begin
              out_valid_nxt = 1'b1;
            end
          end else begin
            case (in_item.key_char)
              KEY_CTRL_P: begin
                out_valid_nxt             = 1'b1;
                out_item_nxt.dump_request = 1'b1;
              end
              KEY_CTRL_U: begin
                // Kick off the kill walk: look at the character before the cursor.
                erase_cnt_nxt = '0;
                if (edit_idx_r == commit_idx_r) begin
                  out_valid_nxt = 1'b1;
                end else begin
                  rd_en     = 1'b1;
                  rd_idx    = edit_prev;
                  state_nxt = ST_KILL_STEP;
                end
              end
              KEY_CTRL_H, KEY_DEL: begin
                out_valid_nxt = 1'b1;
                if (edit_idx_r != commit_idx_r) begin
                  edit_idx_nxt             = edit_prev;
                  out_item_nxt.erase_count = 8'd1;
                end
              end
              default: begin
                out_valid_nxt = 1'b1;
                // Store and echo a non-NUL key while there is room; drop it otherwise.
                if (in_item.key_char != KEY_NUL && fill_level < DEPTH_I) begin
                  wr_en                   = 1'b1;
                  edit_idx_nxt            = idx_next(edit_idx_r);
                  out_item_nxt.echo_valid = 1'b1;
                  out_item_nxt.echo_char  = store_char;
                  // Commit on end of line, end of file, or when this key fills the ring.
                  if (store_char == KEY_LF || store_char == KEY_CTRL_D ||
                      fill_level == DEPTH_M1) begin
                    commit_idx_nxt          = idx_next(edit_idx_r);
                    out_item_nxt.line_ready = 1'b1;
                  end
                end
              end
            endcase
          end
        end
      end

      ST_READ_WAIT: begin
        // Pop the character fetched in the previous cycle.
        out_valid_nxt           = 1'b1;
        out_item_nxt.read_valid = 1'b1;
        out_item_nxt.read_char  = rd_data;
        read_idx_nxt            = idx_next(read_idx_r);
        state_nxt               = ST_IDLE;
      end

      ST_KILL_STEP: begin
        // rd_data holds the character just before edit_idx_r.
        if (rd_data == KEY_LF) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.erase_count = erase_cnt_r;
          state_nxt                = ST_IDLE;
        end else begin
          edit_idx_nxt  = edit_prev;
          erase_cnt_nxt = erase_cnt_inc;
          if (edit_prev == commit_idx_r) begin
            out_valid_nxt            = 1'b1;
            out_item_nxt.erase_count = erase_cnt_inc;
            state_nxt                = ST_IDLE;
          end else begin
            rd_en  = 1'b1;
            rd_idx = edit_prev2;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  // A result beat always lands with the sequencer back in idle.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result beat while sequencer busy");

  // The typed-but-unread span never exceeds the ring.
  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_level <= DEPTH_I)
    else $error("ring holds more than its depth");

  // An accepted beat either answers next cycle or leaves the sequencer busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid_r || busy))
    else $error("accepted beat produced neither a result nor work");

  // A result carries at most one kind of event.
  a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $countones({out_item_r.echo_valid, out_item_r.erase_count != 8'd0,
                                out_item_r.dump_request, out_item_r.read_valid}) <= 1)
    else $error("result mixes event kinds");
`endif

endmodule

### bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cleb_pkg::*;

  // Ring geometry: indices run one bit past the slot address so that a full
  // ring and an empty ring read differently.
  localparam int DEPTH = DEFAULT_BUFFER_DEPTH;
  localparam int IDX_W = $clog2(2 * DEPTH);

  // Stop the random stimulus once this many beats have been offered in all.
  localparam int TOTAL_BEATS = 450;
  // Bound on cycles with no beat moving either way. The slowest legal beat is a
  // full-length kill behind the longest sender gap.
  localparam int WATCHDOG_LIMIT = 20 * (DEPTH + 2);
  // Let any straggler surface after the last reply has come.
  localparam int SETTLE_CYCLES = 2 * DEPTH + 4;

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam cleb_out_t NO_REPLY  = '0;
  localparam cleb_out_t DUMP_ONLY = '{dump_request: 1'b1, default: '0};

  // Keys that end a typed line (Ctrl-U kills it); a NUL ender leaves the line open.
  localparam cleb_char_t LINE_ENDS [5] = '{KEY_CR, KEY_LF, KEY_CTRL_D, KEY_CTRL_U, KEY_NUL};
  localparam cleb_char_t CONTROL_KEYS [8] = '{KEY_CTRL_P, KEY_CTRL_U, KEY_CTRL_H, KEY_DEL,
                                              KEY_NUL, KEY_CR, KEY_LF, KEY_CTRL_D};

  typedef logic [IDX_W-1:0] ring_idx_t;

  // One row of the opening stimulus table. A pinned row carries the reply typed in
  // by hand; the rest fall back to the line-editor predictor.
  typedef struct {
    logic       kind;
    cleb_char_t key;
    bit         pinned;
    cleb_out_t  reply;
  } probe_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  cleb_in_t  in_item;
  logic      out_valid;
  cleb_out_t out_item;

  console_line_edit_buffer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Line-editor predictor state: its own copy of the ring and the three indices.
  // ---------------------------------------------------------------------------
  cleb_char_t line_mem [DEPTH];
  ring_idx_t  pop_idx;
  ring_idx_t  commit_idx;
  ring_idx_t  edit_idx;

  // Replies owed by the block, oldest first.
  cleb_out_t  pending_replies [$];
  cleb_out_t  want;

  int mismatches;
  int burst_left;
  int idle_cycles;
  int key_beats;
  int read_beats;
  int commits;
  int full_commits;
  int longest_kill;
  int dumps;

  probe_row_t opening_rows [25];

  // Work out the reply to one accepted beat and advance the ring state.
  function automatic cleb_out_t predict_reply(cleb_in_t item);
    cleb_out_t  r;
    cleb_char_t c;
    ring_idx_t  back;
    int         erased;
    r = '0;
    erased = 0;
    if (item.kind == KIND_READ) begin
      // Pop only what has been committed.
      if (pop_idx != commit_idx) begin
        r.read_valid = 1'b1;
        r.read_char  = line_mem[pop_idx[IDX_W-2:0]];
        pop_idx      = pop_idx + 1'b1;
      end
      return r;
    end
    case (item.key_char)
      KEY_NUL: ;
      KEY_CTRL_P: r.dump_request = 1'b1;
      KEY_CTRL_U: begin
        // Walk back to the commit point or the last newline, whichever is first.
        back = edit_idx - 1'b1;
        while (edit_idx != commit_idx && line_mem[back[IDX_W-2:0]] != KEY_LF) begin
          edit_idx = back;
          back     = edit_idx - 1'b1;
          erased++;
        end
        r.erase_count = (erased > int'(ERASE_MAX)) ? ERASE_MAX : 8'(erased);
      end
      KEY_CTRL_H, KEY_DEL: begin
        if (edit_idx != commit_idx) begin
          edit_idx      = edit_idx - 1'b1;
          r.erase_count = 8'd1;
        end
      end
      default: begin
        // Store only while the ring has room; a full ring drops the key silently.
        if (ring_idx_t'(edit_idx - pop_idx) < DEPTH) begin
          c = (item.key_char == KEY_CR) ? KEY_LF : item.key_char;
          line_mem[edit_idx[IDX_W-2:0]] = c;
          edit_idx     = edit_idx + 1'b1;
          r.echo_valid = 1'b1;
          r.echo_char  = c;
          if (c == KEY_LF || c == KEY_CTRL_D || ring_idx_t'(edit_idx - pop_idx) == DEPTH) begin
            commit_idx   = edit_idx;
            r.line_ready = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int room_left();
    return DEPTH - int'(ring_idx_t'(edit_idx - pop_idx));
  endfunction

  function automatic int committed_chars();
    return int'(ring_idx_t'(commit_idx - pop_idx));
  endfunction

  // Random key that the editor stores as plain text.
  function automatic cleb_char_t plain_char();
    cleb_char_t c;
    bit         special;
    do begin
      c = cleb_char_t'($urandom_range(1, 255));
      case (c)
        KEY_CTRL_D, KEY_CTRL_H, KEY_LF, KEY_CR, KEY_CTRL_P, KEY_CTRL_U, KEY_DEL: special = 1'b1;
        default: special = 1'b0;
      endcase
    end while (special);
    return c;
  endfunction

  function automatic cleb_out_t echo_reply(cleb_char_t c, logic ready);
    cleb_out_t r;
    r = '0;
    r.echo_valid = 1'b1;
    r.echo_char  = c;
    r.line_ready = ready;
    return r;
  endfunction

  function automatic cleb_out_t erase_reply(int n);
    cleb_out_t r;
    r = '0;
    r.erase_count = 8'(n);
    return r;
  endfunction

  function automatic cleb_out_t pop_reply(cleb_char_t c);
    cleb_out_t r;
    r = '0;
    r.read_valid = 1'b1;
    r.read_char  = c;
    return r;
  endfunction

  // Offer one beat, idling first when the current burst runs out. Hold start high
  // across back-to-back beats; drop it only for a gap.
  task automatic offer_beat(input logic kind, input cleb_char_t key, input bit pinned,
                            input cleb_out_t pinned_reply);
    cleb_in_t  item;
    cleb_out_t reply;
    item.kind     = kind;
    item.key_char = key;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // Mostly short bursts, now and then a long unbroken stretch.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy !== 1'b0);
    reply = predict_reply(item);
    pending_replies.push_back(pinned ? pinned_reply : reply);
    if (kind == KIND_READ) read_beats++;
    else key_beats++;
    if (reply.line_ready) begin
      commits++;
      if (reply.echo_char != KEY_LF && reply.echo_char != KEY_CTRL_D) full_commits++;
    end
    if (int'(reply.erase_count) > longest_kill) longest_kill = int'(reply.erase_count);
    if (reply.dump_request) dumps++;
  endtask

  task automatic send_beat(input logic kind, input cleb_char_t key);
    offer_beat(kind, key, 1'b0, NO_REPLY);
  endtask

  // Type a line of plain text with the odd backspace mixed in, then send the ender unless it is NUL.
  task automatic type_line(input int len, input int edit_pct, input cleb_char_t ender);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(1, 100) <= edit_pct)
        send_beat(KIND_KEY, ($urandom_range(0, 1) == 1) ? KEY_DEL : KEY_CTRL_H);
      else
        send_beat(KIND_KEY, plain_char());
    end
    if (ender != KEY_NUL) send_beat(KIND_KEY, ender);
  endtask

  // Consumer reads; the key field is don't-care, so randomize it.
  task automatic pop_chars(input int n);
    repeat (n) send_beat(KIND_READ, cleb_char_t'($urandom_range(0, 255)));
  endtask

  // Hold the sender off until every owed reply has come back.
  task automatic pause_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  task automatic flag_field(input string name, input logic [7:0] exp_val,
                            input logic [7:0] got_val);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Reply checker: each strobe retires the oldest owed reply, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with nothing owed, expected none, got %0h", $time, out_item);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (out_item.echo_valid !== want.echo_valid)
          flag_field("echo_valid", want.echo_valid, out_item.echo_valid);
        if (out_item.echo_char !== want.echo_char)
          flag_field("echo_char", want.echo_char, out_item.echo_char);
        if (out_item.erase_count !== want.erase_count)
          flag_field("erase_count", want.erase_count, out_item.erase_count);
        if (out_item.line_ready !== want.line_ready)
          flag_field("line_ready", want.line_ready, out_item.line_ready);
        if (out_item.dump_request !== want.dump_request)
          flag_field("dump_request", want.dump_request, out_item.dump_request);
        if (out_item.read_valid !== want.read_valid)
          flag_field("read_valid", want.read_valid, out_item.read_valid);
        if (out_item.read_char !== want.read_char)
          flag_field("read_char", want.read_char, out_item.read_char);
      end
    end
  end

  // Watchdog: any beat taken or reply seen resets the count.
  always @(posedge clk) begin
    if (!rst_n || (start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int n;

    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_item      <= '0;
    idle_cycles  = 0;
    mismatches   = 0;
    burst_left   = 0;
    key_beats    = 0;
    read_beats   = 0;
    commits      = 0;
    full_commits = 0;
    longest_kill = 0;
    dumps        = 0;
    pop_idx      = '0;
    commit_idx   = '0;
    edit_idx     = '0;
    foreach (line_mem[i]) line_mem[i] = '0;

    // Opening table: empty-ring cases right after reset, every control key,
    // byte extremes, CR folding, kill stopping at the commit point.
    opening_rows = '{
      '{KIND_READ, KEY_NUL,    1'b1, NO_REPLY},                  // read with nothing committed
      '{KIND_KEY,  KEY_NUL,    1'b1, NO_REPLY},                  // NUL key is ignored
      '{KIND_KEY,  KEY_CTRL_P, 1'b1, DUMP_ONLY},
      '{KIND_KEY,  KEY_CTRL_H, 1'b1, NO_REPLY},                  // nothing to erase
      '{KIND_KEY,  KEY_DEL,    1'b1, NO_REPLY},
      '{KIND_KEY,  KEY_CTRL_U, 1'b1, NO_REPLY},
      '{KIND_KEY,  8'h61,      1'b1, echo_reply(8'h61, 1'b0)},
      '{KIND_KEY,  8'h62,      1'b1, echo_reply(8'h62, 1'b0)},
      '{KIND_KEY,  KEY_DEL,    1'b1, erase_reply(1)},
      '{KIND_KEY,  KEY_CTRL_H, 1'b1, erase_reply(1)},
      '{KIND_KEY,  8'hff,      1'b1, echo_reply(8'hff, 1'b0)},
      '{KIND_KEY,  8'h80,      1'b0, NO_REPLY},
      '{KIND_KEY,  8'h01,      1'b0, NO_REPLY},
      '{KIND_KEY,  KEY_CTRL_U, 1'b1, erase_reply(3)},
      '{KIND_KEY,  8'h7e,      1'b0, NO_REPLY},
      '{KIND_KEY,  KEY_CR,     1'b1, echo_reply(KEY_LF, 1'b1)},  // CR stored as LF, commits
      '{KIND_READ, 8'hff,      1'b1, pop_reply(8'h7e)},
      '{KIND_READ, KEY_NUL,    1'b1, pop_reply(KEY_LF)},
      '{KIND_READ, 8'h5a,      1'b1, NO_REPLY},                  // drained again
      '{KIND_KEY,  8'h55,      1'b0, NO_REPLY},
      '{KIND_KEY,  KEY_CTRL_D, 1'b1, echo_reply(KEY_CTRL_D, 1'b1)},
      '{KIND_KEY,  KEY_CTRL_U, 1'b1, NO_REPLY},                  // kill stops at commit point
      '{KIND_KEY,  KEY_LF,     1'b1, echo_reply(KEY_LF, 1'b1)},  // empty line commits
      '{KIND_READ, 8'h00,      1'b0, NO_REPLY},
      '{KIND_READ, 8'h00,      1'b0, NO_REPLY}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i])
      offer_beat(opening_rows[i].kind, opening_rows[i].key, opening_rows[i].pinned,
                 opening_rows[i].reply);

    // Fill the ring to the brim: the last stored key commits by itself, the next
    // two are dropped, and a backspace on the committed ring does nothing.
    type_line(room_left() + 2, 0, KEY_NUL);
    send_beat(KIND_KEY, KEY_CTRL_H);
    pause_until_drained();
    pop_chars(committed_chars() + 1);

    // One long kill across most of the ring.
    n = $urandom_range(room_left() * 3 / 4, room_left() - 1);
    type_line(n, 0, KEY_CTRL_U);

    // Random part: mostly well-formed typing sessions with random text, readers
    // draining behind them, plus raw noise and control-key bursts.
    while (key_beats + read_beats < TOTAL_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        type_line($urandom_range(0, 12), 15, LINE_ENDS[$urandom_range(0, 4)]);
        pop_chars($urandom_range(0, committed_chars() + 2));
      end else if (pick < 65) begin
        pop_chars($urandom_range(1, 10));
      end else if (pick < 77) begin
        repeat ($urandom_range(1, 8))
          send_beat(logic'($urandom_range(0, 1)), cleb_char_t'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        type_line($urandom_range(20, 130), 3, LINE_ENDS[$urandom_range(0, 4)]);
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 4)) send_beat(KIND_KEY, CONTROL_KEYS[$urandom_range(0, 7)]);
      end else begin
        pause_until_drained();
      end
    end

    // Stop driving, collect what is owed, then let any stray strobe show up.
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run drove %0d key beats and %0d read beats; %0d lines committed, %0d on a full ring.",
             key_beats, read_beats, commits, full_commits);
    $display("Longest kill erased %0d characters; %0d dump requests seen.", longest_kill, dumps);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
